[hdl/tdp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared constants and command/status types of the trial division prime test.
// ----------------------------------------------------------------------------
package tdp_pkg;

  localparam int TABLE_DEPTH = 8192;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int VALUE_W     = 31;
  localparam int PRIME_W     = 16;
  localparam int SQ_W        = 2 * PRIME_W;
  localparam int DIV_CNT_W   = $clog2(VALUE_W);

  localparam logic [PRIME_W-1:0]   FIRST_PRIME = PRIME_W'(2);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(VALUE_W - 1);
  localparam logic [COUNT_W-1:0]   COUNT_RESET = COUNT_W'(1);
  localparam logic [COUNT_W-1:0]   COUNT_FULL  = COUNT_W'(TABLE_DEPTH);

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture a new candidate, rewind the table index
    logic latch_p;    // capture the table entry at the current index
    logic sq_init;    // square the divisor, arm the remainder unit
    logic div_step;   // one restoring remainder step
    logic next_k;     // advance to the next table entry
    logic verdict_we; // record the verdict
    logic verdict;    // 1 = prime
    logic emit;       // load the result register, append if due
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic below_two;  // candidate below two
    logic k_end;      // every stored entry has been walked
    logic p_zero;     // current entry is zero
    logic sq_gt;      // divisor squared exceeds the candidate
    logic div_last;   // remainder unit takes its last step this cycle
    logic rem_zero;   // divisor divides the candidate
    logic out_free;   // result register may be loaded this cycle
  } sts_t;

endpackage
`default_nettype wire

[hdl/tdp_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/tdp_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_datapath
// Candidate and table registers, prime table RAM, squarer, bit-serial
// remainder unit and the result register.
// ----------------------------------------------------------------------------
module tdp_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          func,
  input  wire logic [tdp_pkg::VALUE_W-1:0]   value,
  input  wire tdp_pkg::cmd_t                 cmd,
  output tdp_pkg::sts_t                      sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               is_prime,
  output logic      [tdp_pkg::VALUE_W-1:0]   number,
  output logic                               appended,
  output logic                               refused
);
  import tdp_pkg::*;

  logic [VALUE_W-1:0]   value_r;
  logic                 func_r;
  logic [COUNT_W-1:0]   k;
  logic [COUNT_W-1:0]   count;
  logic [PRIME_W-1:0]   p;
  logic [SQ_W-1:0]      sq;
  logic [PRIME_W-1:0]   rem;
  logic [VALUE_W-1:0]   dividend;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 verdict;
  logic [PRIME_W-1:0]   rdata;

  logic [PRIME_W:0]     rem_sh;
  logic [PRIME_W:0]     rem_diff;
  logic                 learn_hit;
  logic                 can_store;
  logic                 do_append;

  assign rem_sh    = {rem, dividend[VALUE_W-1]};
  assign rem_diff  = rem_sh - {1'b0, p};
  assign learn_hit = func_r && verdict;
  assign can_store = (count < COUNT_FULL) && (value_r[VALUE_W-1:PRIME_W] == '0);
  assign do_append = cmd.emit && learn_hit && can_store;

  tdp_ram #(
    .WIDTH (PRIME_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (do_append),
    .waddr (count[ADDR_W-1:0]),
    .wdata (value_r[PRIME_W-1:0]),
    .raddr (k[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    sts.below_two = (value_r[VALUE_W-1:1] == '0);
    sts.k_end     = (k >= count);
    sts.p_zero    = (p == '0);
    sts.sq_gt     = (sq > {1'b0, value_r});
    sts.div_last  = (div_cnt == DIV_LAST);
    sts.rem_zero  = (rem == '0);
    sts.out_free  = !out_valid || out_ready;
  end

  // Candidate, walk and remainder registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= value;
      func_r  <= func;
      k       <= '0;
    end
    if (cmd.next_k) begin
      k <= k + COUNT_W'(1);
    end
    if (cmd.latch_p) begin
      // entry zero holds the first prime from reset and is never written
      p <= (k == '0) ? FIRST_PRIME : rdata;
    end
    if (cmd.sq_init) begin
      sq       <= SQ_W'({{PRIME_W{1'b0}}, p} * {{PRIME_W{1'b0}}, p});
      rem      <= '0;
      dividend <= value_r;
      div_cnt  <= '0;
    end
    if (cmd.div_step) begin
      rem      <= (rem_sh >= {1'b0, p}) ? rem_diff[PRIME_W-1:0] : rem_sh[PRIME_W-1:0];
      dividend <= {dividend[VALUE_W-2:0], 1'b0};
      div_cnt  <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.verdict_we) begin
      verdict <= cmd.verdict;
    end
  end

  // Table fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= COUNT_RESET;
    end else if (do_append) begin
      count <= count + COUNT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      is_prime <= verdict;
      number   <= value_r;
      appended <= learn_hit && can_store;
      refused  <= learn_hit && !can_store;
    end
  end

endmodule
`default_nettype wire

[hdl/tdp_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_ctrl
// Sequencer of the table walk: fetch, square test, remainder, verdict.
// ----------------------------------------------------------------------------
module tdp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tdp_pkg::sts_t sts,
  output tdp_pkg::cmd_t      cmd
);
  import tdp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_FETCH,
    S_SQUARE,
    S_COMPARE,
    S_DIVIDE,
    S_DECIDE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.below_two) begin
          cmd.verdict_we = 1'b1;
          cmd.verdict    = 1'b0;
          state_next     = S_FINISH;
        end else if (sts.k_end) begin
          cmd.verdict_we = 1'b1;
          cmd.verdict    = 1'b1;
          state_next     = S_FINISH;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.latch_p = 1'b1;
        state_next  = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.sq_init = 1'b1;
        state_next  = S_COMPARE;
      end
      S_COMPARE: begin
        if (sts.p_zero) begin
          cmd.next_k = 1'b1;
          state_next = S_START;
        end else if (sts.sq_gt) begin
          cmd.verdict_we = 1'b1;
          cmd.verdict    = 1'b1;
          state_next     = S_FINISH;
        end else begin
          state_next = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.rem_zero) begin
          cmd.verdict_we = 1'b1;
          cmd.verdict    = 1'b0;
          state_next     = S_FINISH;
        end else begin
          cmd.next_k = 1'b1;
          state_next = S_START;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

[hdl/trial_division_prime_test_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Trial division primality tester with a learnable table of small primes.
// ----------------------------------------------------------------------------
// Walk: each entry tried by division passes the start, fetch, square, compare,
//   remainder and decide states; the walk ends on the square test, on running
//   out of table, on a candidate below two or on a dividing entry, and a held result adds its wait.
// Throughput: one transaction at a time; the next is taken once the result
//   is loaded. The 31-step bit-serial remainder unit sets the cost per entry.
// Reset: synchronous; table holds only 2, fill count one, no result pending.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        func,
  input  wire logic [tdp_pkg::VALUE_W-1:0] value,
  // output channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             is_prime,
  output logic      [tdp_pkg::VALUE_W-1:0] number,
  output logic                             appended,
  output logic                             refused
);
  import tdp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the walk: one table entry per pass, fetch, square, divide
  tdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the candidate, the table and the result register
  tdp_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_prime  (is_prime),
    .number    (number),
    .appended  (appended),
    .refused   (refused)
  );

  // A result never claims both an append and a refusal
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(appended && refused))
    else $error("append and refuse flagged together");

  // Append or refusal only follows a prime verdict
  a_flags_need_prime: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (appended || refused)) |-> is_prime)
    else $error("append flag on a composite candidate");

  // Block turns busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a candidate is in work");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result register overwritten");

endmodule
`default_nettype wire

[dv/trial_division_prime_test_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_top_test
// Self-checking bench for the trial division prime tester. A queue-fed driver
// offers candidates, a monitor predicts each verdict from its own copy of the
// prime table and checks every result transaction in order. The run covers
// the corner candidates, a random mix of test and learn traffic and a long
// receiver hold.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top_test;

  import tdp_pkg::*;

  // Function codes of the input transaction
  typedef enum logic {
    FN_TEST  = 1'b0,
    FN_LEARN = 1'b1
  } fn_t;

  typedef struct packed {
    fn_t                func;
    logic [VALUE_W-1:0] value;
  } cand_t;

  typedef struct packed {
    logic               is_prime;
    logic [VALUE_W-1:0] number;
    logic               appended;
    logic               refused;
  } verdict_t;

  localparam int unsigned VALUE_MAX    = (32'd1 << VALUE_W) - 32'd1;
  localparam int unsigned PRIME_MAX    = (1 << PRIME_W) - 1;
  localparam int          N_RANDOM     = 470;
  // Keep the table short during random traffic so that no walk runs long
  localparam int unsigned LEARN_CAP    = 600;
  localparam int          HOLD_START   = 6000;
  localparam int          HOLD_LEN     = 1500;
  localparam int          DRAIN_CYCLES = 100;
  localparam int          IDLE_LIMIT   = 200000;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               func      = 1'b0;
  logic [VALUE_W-1:0] value     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               is_prime;
  logic [VALUE_W-1:0] number;
  logic               appended;
  logic               refused;

  // Candidates waiting for the driver, verdicts waiting for the result port
  cand_t    cand_q[$];
  verdict_t verdict_q[$];

  // Predicted prime table
  logic [PRIME_W-1:0] prime_list [TABLE_DEPTH];
  int unsigned        prime_cnt;

  int unsigned n_err      = 0;
  int unsigned n_results  = 0;
  int unsigned n_primes   = 0;
  int unsigned n_appended = 0;
  int unsigned n_refused  = 0;

  int unsigned cyc       = 0;
  logic        hold_off  = 1'b0;
  logic        calm      = 1'b0;

  trial_division_prime_test_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_prime  (is_prime),
    .number    (number),
    .appended  (appended),
    .refused   (refused)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walk the predicted table for one candidate and update it in learn mode.
  // The square test comes before the divisibility test, so a candidate equal
  // to a stored prime is judged prime; running off the end also means prime.
  function automatic verdict_t judge_candidate(input fn_t fn, input logic [VALUE_W-1:0] cand);
    verdict_t    r;
    int unsigned v;
    int unsigned p;
    int unsigned k;
    bit          prime;
    bit          done;
    v      = {1'b0, cand};
    prime  = (v >= 2);
    done   = !prime;
    for (k = 0; k < prime_cnt && !done; k++) begin
      p = 32'(prime_list[k]);
      if (p != 0) begin
        if (v / p < p) begin
          done = 1'b1;
        end else if (v % p == 0) begin
          prime = 1'b0;
          done  = 1'b1;
        end
      end
    end
    r.is_prime = prime;
    r.number   = cand;
    r.appended = 1'b0;
    r.refused  = 1'b0;
    if (fn == FN_LEARN && prime) begin
      if (prime_cnt < TABLE_DEPTH && v <= PRIME_MAX) begin
        prime_list[prime_cnt] = PRIME_W'(v);
        prime_cnt++;
        r.appended = 1'b1;
      end else begin
        r.refused = 1'b1;
      end
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one; none during calm stretches
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  // Bias candidates toward small values, which keep table walks short
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) return VALUE_W'($urandom_range(0, 15));
    if (sel < 50) return VALUE_W'($urandom_range(16, 1023));
    if (sel < 85) return VALUE_W'($urandom_range(1024, PRIME_MAX));
    if (sel < 92) return VALUE_W'(VALUE_MAX - $urandom_range(0, 255));
    return VALUE_W'($urandom());
  endfunction

  // Driver: present one candidate at a time, hold it until accepted, then
  // wait out a random gap before the next one.
  always @(posedge clk) begin : drv
    cand_t       c;
    int unsigned gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      func     <= FN_TEST;
      value    <= '0;
      gap_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cand_q.size() != 0) begin
        c = cand_q.pop_front();
        in_valid <= 1'b1;
        func     <= c.func;
        value    <= c.value;
        gap_left = next_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check the result transaction first, then predict the input
  // transaction of the same edge, then pick the next state of out_ready.
  always @(posedge clk) begin : mon
    verdict_t    got;
    verdict_t    want;
    int unsigned stall_left;
    if (rst) begin
      out_ready     <= 1'b0;
      stall_left    = 0;
      prime_cnt     = 1;
      prime_list[0] = FIRST_PRIME;
    end else begin
      if (out_valid && out_ready) begin
        got.is_prime = is_prime;
        got.number   = number;
        got.appended = appended;
        got.refused  = refused;
        n_results++;
        n_primes   += 32'(is_prime);
        n_appended += 32'(appended);
        n_refused  += 32'(refused);
        if (verdict_q.size() == 0) begin
          $error("result for number %0d with no candidate pending", number);
          n_err++;
        end else begin
          want = verdict_q.pop_front();
          if (got.is_prime !== want.is_prime) begin
            $error("is_prime: expected %0d, actual %0d", want.is_prime, got.is_prime);
            n_err++;
          end
          if (got.number !== want.number) begin
            $error("number: expected %0d, actual %0d", want.number, got.number);
            n_err++;
          end
          if (got.appended !== want.appended) begin
            $error("appended: expected %0d, actual %0d", want.appended, got.appended);
            n_err++;
          end
          if (got.refused !== want.refused) begin
            $error("refused: expected %0d, actual %0d", want.refused, got.refused);
            n_err++;
          end
        end
      end
      if (in_valid && in_ready) begin
        verdict_q.insert(verdict_q.size(), judge_candidate(fn_t'(func), value));
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = next_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Count cycles; hold the receiver off once for a long stretch so the
  // block fills up and stalls its input, and open calm stretches with no
  // idling on either side.
  always @(posedge clk) begin
    if (rst) begin
      cyc      <= 0;
      hold_off <= 1'b0;
      calm     <= 1'b0;
    end else begin
      cyc      <= cyc + 1;
      hold_off <= (cyc >= HOLD_START) && (cyc < HOLD_START + HOLD_LEN);
      calm     <= (cyc % 4096) >= 3072;
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic offer(input fn_t fn, input int unsigned v);
    cand_t c;
    c.func  = fn;
    c.value = VALUE_W'(v);
    cand_q.insert(cand_q.size(), c);
  endtask

  // Block until every candidate is accepted and every verdict has arrived
  task automatic wait_idle();
    while (cand_q.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
  endtask

  initial begin : stim
    cand_t       c;
    int          i;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Corner candidates against the reset table, which holds only 2
    offer(FN_TEST,  0);
    offer(FN_LEARN, 0);
    offer(FN_LEARN, 1);
    offer(FN_TEST,  2);              // equal to a stored prime
    offer(FN_TEST,  4);
    offer(FN_TEST,  9);              // composite passed by an exhausted table
    offer(FN_LEARN, 65537);          // prime wider than 16 bits: refused
    offer(FN_TEST,  VALUE_MAX);
    offer(FN_TEST,  VALUE_MAX - 1);
    // Grow the table, including a duplicate and a stored composite
    offer(FN_LEARN, 3);
    offer(FN_LEARN, 5);
    offer(FN_LEARN, 7);
    offer(FN_LEARN, 9);
    offer(FN_LEARN, 11);
    offer(FN_LEARN, 13);
    offer(FN_LEARN, 3);
    offer(FN_LEARN, 25);
    offer(FN_LEARN, 289);
    offer(FN_TEST,  PRIME_MAX);
    offer(FN_LEARN, PRIME_MAX + 1);
    offer(FN_TEST,  1);
    offer(FN_TEST,  VALUE_MAX);
    offer(FN_TEST,  VALUE_MAX >> 1);

    // Random mix; keep at most two candidates queued so the learn cap holds
    for (i = 0; i < N_RANDOM; i++) begin
      while (cand_q.size() > 1) @(negedge clk);
      c.value = pick_value();
      c.func  = fn_t'($urandom_range(0, 1));
      if (c.func == FN_LEARN && prime_cnt >= LEARN_CAP && c.value <= VALUE_W'(PRIME_MAX))
        c.func = FN_TEST;
      cand_q.insert(cand_q.size(), c);
    end
    offer(FN_LEARN, 65521);          // largest 16-bit prime
    wait_idle();

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d verdicts: %0d prime, %0d appended, %0d refused.",
             n_results, n_primes, n_appended, n_refused);
    $display("Prime table reached %0d of %0d entries; receiver held off %0d cycles once.",
             prime_cnt, TABLE_DEPTH, HOLD_LEN);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/tdp_pkg.sv
hdl/tdp_ram.sv
hdl/tdp_datapath.sv
hdl/tdp_ctrl.sv
hdl/trial_division_prime_test_top.sv
dv/trial_division_prime_test_top_test.sv
